// File: hw/rtl/flpa_pkg.sv
// ----------------------------------------------------------------------------
// Free list pool allocator package
// Shared widths, opcodes, status codes, register indexes and types of the
// chunk pool allocator and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package flpa_pkg;

   // Field widths fixed by the interface.
   localparam int OPCODE_W = 2;
   localparam int OFFSET_W = 16;
   localparam int FREE_W   = 11;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 17;

   // Divider operand width: covers both the buffer length and a byte offset.
   localparam int DIV_W     = 17;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_INIT    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NULL  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_BYTES   = 2'd1;

   // Configuration reset values.
   localparam logic [CSR_DATA_W-1:0] BUFFER_LENGTH_RST = 17'h10000;
   localparam logic [CSR_DATA_W-1:0] CHUNK_BYTES_RST   = 17'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_FILL,
      ST_ALLOC_RD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/flpa_div.sv
// ----------------------------------------------------------------------------
// Pool allocator divider
// Restoring unsigned divider, one quotient bit per cycle. The caller never
// starts it with a zero divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module flpa_div (
   input  wire                       clock,
   input  wire                       reset,
   input  flpa_pkg::div_req_type     div_req,
   output flpa_pkg::div_rsp_type     div_rsp
);

   localparam int DW = flpa_pkg::DIV_W;
   localparam int CW = flpa_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff,  cnt_in;
   logic [DW-1:0] quo_ff,  quo_in;
   logic [DW-1:0] rem_ff,  rem_in;
   logic [DW-1:0] dvs_ff,  dvs_in;

   logic [DW:0]   rem_sh;
   logic [DW:0]   diff;
   logic          fits;

   // The dividend shifts out of the top of quo_ff while quotient bits enter
   // at the bottom.
   assign rem_sh = {rem_ff, quo_ff[DW-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign fits   = !diff[DW];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], fits};
         rem_in = fits ? diff[DW-1:0] : rem_sh[DW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// File: hw/rtl/free_list_pool_allocator.sv
// ----------------------------------------------------------------------------
// Free list pool allocator
// Fixed-size chunk allocator kept as a LIFO linked free list in a link RAM.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+-----------------------
//  req     | req_valid, req_stall, opcode/offset/null | request in
//  rsp     | rsp_valid, rsp_stall, offset/free/status | one response per req
//  csr     | csr_valid, csr_ready, index, wdata       | register write in
//
//  One request is worked on at a time; the next is taken while a response
//  still waits in the output register.
//  An allocate reads the link RAM once, a release waits on the divider, and an
//  init waits on the divider and then writes one link RAM entry per chunk. An
//  unused opcode, an allocate from an empty pool, a null release, and an init
//  or release while the chunk size is zero go straight to the final step.
//  Reset clears the pool to empty with no chunks; the link RAM needs no
//  clearing, since init writes every entry before it can be read.
//  A stalled response holds the block at its final step until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_pool_allocator #(
   parameter int unsigned MAX_CHUNKS = 1024,
   parameter int unsigned BUF_BYTES  = 65536
) (
   input  wire                              clock,
   input  wire                              reset,

   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [flpa_pkg::OPCODE_W-1:0]    req_opcode,
   input  wire  [flpa_pkg::OFFSET_W-1:0]    req_byte_offset,
   input  wire                              req_null_pointer,

   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [flpa_pkg::OFFSET_W-1:0]    rsp_chunk_offset,
   output logic [flpa_pkg::FREE_W-1:0]      rsp_free_chunks,
   output logic [flpa_pkg::STATUS_W-1:0]    rsp_status,

   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [flpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [flpa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(MAX_CHUNKS);
   localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
   localparam int DW    = flpa_pkg::DIV_W;
   localparam int OW    = flpa_pkg::OFFSET_W;
   localparam int SW    = flpa_pkg::STATUS_W;
   localparam int PW    = IDX_W + OW;
   localparam logic [31:0] BUF_LIM = 32'(BUF_BYTES);

   // Control and configuration state.
   flpa_pkg::state_type state_ff, state_in;
   logic [flpa_pkg::OPCODE_W-1:0]   op_ff,     op_in;
   logic [IDX_W-1:0]                head_ff,   head_in;
   logic [CNT_W-1:0]                free_ff,   free_in;
   logic [CNT_W-1:0]                ctot_ff,   ctot_in;
   logic [IDX_W-1:0]                fill_ff,   fill_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [flpa_pkg::CSR_DATA_W-1:0] blen_ff,   blen_in;
   logic [flpa_pkg::CSR_DATA_W-1:0] cbytes_ff, cbytes_in;

   // Result payload.
   logic [OW-1:0]                   res_off_ff,    res_off_in;
   logic [SW-1:0]                   res_status_ff, res_status_in;
   logic [OW-1:0]                   rsp_off_ff,    rsp_off_in;
   logic [flpa_pkg::FREE_W-1:0]     rsp_free_ff,   rsp_free_in;
   logic [SW-1:0]                   rsp_status_ff, rsp_status_in;

   // Link RAM.
   logic [IDX_W-1:0] link_mem [MAX_CHUNKS];
   logic [IDX_W-1:0] mem_rdata_ff;
   logic             mem_re;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_wdata;

   flpa_pkg::div_req_type div_req;
   flpa_pkg::div_rsp_type div_rsp;

   logic [DW-1:0]    len_clamp;
   logic [PW-1:0]    prod_full;
   logic [CNT_W-1:0] quo_sat;
   logic [CNT_W-1:0] ctot_dec;
   logic             out_free;

   flpa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign len_clamp = (32'(blen_ff) > BUF_LIM) ? BUF_LIM[DW-1:0] : blen_ff;
   assign prod_full = PW'(head_ff) * PW'(cbytes_ff[OW-1:0]);
   assign quo_sat   = (div_rsp.quotient > DW'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
                                                          : div_rsp.quotient[CNT_W-1:0];
   assign ctot_dec  = ctot_ff - CNT_W'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration must only be written while no request is in flight; the block itself does not enforce it.
   assign csr_ready = 1'b1;

   always_comb begin
      blen_in   = blen_ff;
      cbytes_in = cbytes_ff;
      if (csr_valid) begin
         case (csr_index)
            flpa_pkg::CSR_BUFFER_LENGTH: blen_in   = csr_wdata;
            flpa_pkg::CSR_CHUNK_BYTES:   cbytes_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      ctot_in       = ctot_ff;
      fill_in       = fill_ff;
      res_off_in    = res_off_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_off_in    = rsp_off_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_status_in = rsp_status_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = fill_ff;
      mem_wdata     = head_ff;
      div_req.start    = 1'b0;
      div_req.dividend = len_clamp;
      div_req.divisor  = cbytes_ff;
      req_stall     = 1'b1;

      case (state_ff)
         flpa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in         = req_opcode;
               res_off_in    = '0;
               res_status_in = flpa_pkg::STATUS_OK;
               state_in      = flpa_pkg::ST_FINISH;
               case (req_opcode)
                  flpa_pkg::OP_INIT: begin
                     if (cbytes_ff == '0) begin
                        ctot_in = '0;
                        head_in = '0;
                        free_in = '0;
                     end else begin
                        div_req.start = 1'b1;
                        state_in      = flpa_pkg::ST_DIV;
                     end
                  end
                  flpa_pkg::OP_ALLOC: begin
                     if (free_ff == '0) begin
                        res_status_in = flpa_pkg::STATUS_EMPTY;
                     end else begin
                        mem_re     = 1'b1;
                        res_off_in = prod_full[OW-1:0];
                        state_in   = flpa_pkg::ST_ALLOC_RD;
                     end
                  end
                  flpa_pkg::OP_RELEASE: begin
                     if (req_null_pointer) begin
                        res_status_in = flpa_pkg::STATUS_NULL;
                     end else if (cbytes_ff == '0) begin
                        res_status_in = flpa_pkg::STATUS_RANGE;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DW'(req_byte_offset);
                        state_in         = flpa_pkg::ST_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end

         flpa_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               state_in = flpa_pkg::ST_FINISH;
               if (op_ff == flpa_pkg::OP_INIT) begin
                  ctot_in = quo_sat;
                  if (quo_sat == '0) begin
                     head_in = '0;
                     free_in = '0;
                  end else begin
                     fill_in  = '0;
                     state_in = flpa_pkg::ST_FILL;
                  end
               end else if (div_rsp.quotient >= DW'(ctot_ff)) begin
                  res_status_in = flpa_pkg::STATUS_RANGE;
               end else begin
                  // Push the released chunk on the head of the list.
                  mem_we    = 1'b1;
                  mem_waddr = div_rsp.quotient[IDX_W-1:0];
                  mem_wdata = head_ff;
                  head_in   = div_rsp.quotient[IDX_W-1:0];
                  if (free_ff < CNT_W'(MAX_CHUNKS)) begin
                     free_in = free_ff + CNT_W'(1);
                  end
               end
            end
         end

         flpa_pkg::ST_FILL: begin
            // Chunk i links to chunk i-1, chunk zero to itself.
            mem_we    = 1'b1;
            mem_waddr = fill_ff;
            mem_wdata = (fill_ff == '0) ? '0 : fill_ff - IDX_W'(1);
            fill_in   = fill_ff + IDX_W'(1);
            if (fill_ff == ctot_dec[IDX_W-1:0]) begin
               head_in  = ctot_dec[IDX_W-1:0];
               free_in  = ctot_ff;
               state_in = flpa_pkg::ST_FINISH;
            end
         end

         flpa_pkg::ST_ALLOC_RD: begin
            head_in  = mem_rdata_ff;
            free_in  = free_ff - CNT_W'(1);
            state_in = flpa_pkg::ST_FINISH;
         end

         flpa_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_off_in    = res_off_ff;
               rsp_free_in   = flpa_pkg::FREE_W'(free_ff);
               rsp_status_in = res_status_ff;
               state_in      = flpa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = flpa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flpa_pkg::ST_IDLE;
         op_ff        <= flpa_pkg::OP_INIT;
         head_ff      <= '0;
         free_ff      <= '0;
         ctot_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         blen_ff      <= flpa_pkg::BUFFER_LENGTH_RST;
         cbytes_ff    <= flpa_pkg::CHUNK_BYTES_RST;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         ctot_ff      <= ctot_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         blen_ff      <= blen_in;
         cbytes_ff    <= cbytes_in;
      end
   end

   always_ff @(posedge clock) begin
      res_off_ff    <= res_off_in;
      res_status_ff <= res_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= link_mem[head_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chunk_offset = rsp_off_ff;
   assign rsp_free_chunks  = rsp_free_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTH
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      (free_ff <= CNT_W'(MAX_CHUNKS)) && (ctot_ff <= CNT_W'(MAX_CHUNKS)))
      else $error("free or chunk count above the pool limit");

   a_mem_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == flpa_pkg::ST_FILL || state_ff == flpa_pkg::ST_DIV))
      else $error("link RAM written outside fill or release");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == flpa_pkg::ST_DIV)
      else $error("divider finished while not awaited");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flpa_pkg::ST_FINISH && rsp_valid_ff && rsp_stall)
      |=> state_ff == flpa_pkg::ST_FINISH)
      else $error("response overwritten while the output register was full");
`endif

endmodule

`default_nettype wire
